>>> rtl/rgb_3x3_window_filter_macros.svh
// Assertion macros for the RGB 3x3 window filter.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef RGB_3X3_WINDOW_FILTER_MACROS_SVH
`define RGB_3X3_WINDOW_FILTER_MACROS_SVH

// When the antecedent holds, the consequent must hold on the same edge.
`define RGB3_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// When the antecedent holds, the consequent must hold on the next edge.
`define RGB3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/rgb3_pkg.sv
// Shared types, constants and helpers of the RGB 3x3 window filter.
// No dependencies; the control, window, kernel, top level and bench files import this package.
package rgb3_pkg;

  // Largest supported frame side and the widths that follow from it.
  localparam int MAX_DIM = 1024;
  localparam int ADDR_W  = $clog2(MAX_DIM);
  localparam int COL_W   = ADDR_W;
  localparam int ROW_W   = $clog2(MAX_DIM + 2);

  // Fixed register and counter widths.
  localparam int DIM_W      = 11;
  localparam int CNT_W      = 21;
  localparam int STEP_W     = $clog2(CNT_W + 1);
  localparam int CFG_IDX_W  = 1;
  localparam int SIZE_RESET = 1024;

  // Output queue.
  localparam int OQ_DEPTH = 8;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 1'b1;

  // Filter modes; the fourth code passes the centre pixel through.
  localparam logic [1:0] MODE_BOX     = 2'd0;
  localparam logic [1:0] MODE_SHARPEN = 2'd1;
  localparam logic [1:0] MODE_TRIM    = 2'd2;

  // Item kinds.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Reciprocals for division by nine and seven: (x * RECIP) >> RECIP_SH.
  localparam int         RECIP_SH = 15;
  localparam logic [12:0] RECIP_9 = 13'd3641;
  localparam logic [12:0] RECIP_7 = 13'd4682;

  // Intensity seed of the minimum search, above any real intensity.
  localparam logic [9:0] INT_SEED = 10'd766;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

  // Per item result bookkeeping.
  typedef struct packed {
    logic produce;
    logic border;
    logic frame_end;
  } tag_t;

  // Line store read request issued at the accepting edge.
  typedef struct packed {
    logic             accept;
    logic [COL_W-1:0] col;
  } rd_req_t;

  // Accepted item, registered in the cycle after acceptance.
  typedef struct packed {
    logic             valid;
    logic [COL_W-1:0] col;
    pixel_t           px;
    tag_t             tag;
  } front_t;

  typedef struct packed {
    logic   frame_end;
    pixel_t px;
  } result_t;

  typedef enum logic {
    ST_RUN,
    ST_DIV
  } ctl_state_t;

  // Channel k of a pixel: red, green, blue.
  function automatic logic [7:0] chan(input pixel_t p, input int k);
    logic [7:0] v;
    case (k)
      0:       v = p.r;
      1:       v = p.g;
      default: v = p.b;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/rgb3_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; read during write at one address returns the old data.
module rgb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/rgb3_ctrl.sv
// Control of the RGB 3x3 window filter: registers, frame position, handshake
// and the serial divider that re-derives row and column after a size change.
// Depends on rgb3_pkg.
module rgb3_ctrl import rgb3_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 s_axis_tvalid,
  input  logic [23:0]          s_axis_tdata,
  input  logic                 s_axis_tuser,
  input  logic                 room,
  output logic                 s_axis_tready,
  output rd_req_t              rd_req,
  output front_t               front,
  output logic                 claim,
  output logic [1:0]           filter_mode
);

  ctl_state_t state, state_next;

  logic [DIM_W-1:0]  image_size;
  logic [DIM_W-1:0]  n;
  logic [CNT_W-1:0]  cnt;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [CNT_W-1:0]  dvd, dvd_next;
  logic [DIM_W-1:0]  rem, rem_next;
  logic [STEP_W-1:0] step;
  logic              accept, div_start, div_last, div_over;
  logic              last_item, col_end;
  tag_t              tag;
  pixel_t            px;

  // Effective frame side.
  always_comb begin
    if (image_size == '0) begin
      n = DIM_W'(1);
    end else if (32'(image_size) > MAX_DIM) begin
      n = DIM_W'(MAX_DIM);
    end else begin
      n = image_size;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_RUN: begin
        if (div_start) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_last && !div_start) state_next = ST_RUN;
      end
      default: state_next = ST_RUN;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    case (state)
      ST_RUN:  s_axis_tready = room;
      ST_DIV:  s_axis_tready = 1'b0;
      default: s_axis_tready = 1'b0;
    endcase
  end

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign div_start = cfg_we && (cfg_index == REG_IMAGE_SIZE);
  assign div_last  = (step == STEP_W'(CNT_W - 1));

  // One restoring division step: item count over the frame side.
  always_comb begin
    logic [DIM_W:0] rem_sh;
    rem_sh   = {rem, dvd[CNT_W-1]};
    if (rem_sh >= {1'b0, n}) begin
      rem_next = DIM_W'(rem_sh - {1'b0, n});
      dvd_next = {dvd[CNT_W-2:0], 1'b1};
    end else begin
      rem_next = rem_sh[DIM_W-1:0];
      dvd_next = {dvd[CNT_W-2:0], 1'b0};
    end
    div_over = (dvd_next > CNT_W'(n) + CNT_W'(1)) ||
               ((dvd_next == CNT_W'(n) + CNT_W'(1)) && (rem_next != '0));
  end

  // Position of this item and of the pixel it releases.
  always_comb begin
    int r_i;
    int c_i;
    last_item = (32'(row) == 32'(n) + 1) && (col == '0);
    col_end   = (32'(col) == 32'(n) - 1);
    if (col == '0) begin
      c_i = 32'(n) - 1;
      r_i = 32'(row) - 2;
    end else begin
      c_i = 32'(col) - 1;
      r_i = 32'(row) - 1;
    end
    tag.produce   = (32'(row) >= 2) || ((32'(row) == 1) && (col != '0));
    tag.border    = (r_i == 0) || (c_i == 0) || (r_i == 32'(n) - 1) ||
                    (c_i == 32'(n) - 1);
    tag.frame_end = last_item;
    if (s_axis_tuser == OP_FLUSH) begin
      px = '0;
    end else begin
      px.r = s_axis_tdata[7:0];
      px.g = s_axis_tdata[15:8];
      px.b = s_axis_tdata[23:16];
    end
  end

  assign rd_req.accept = accept;
  assign rd_req.col    = col;
  assign claim         = accept && tag.produce;

  // Registers, frame counters and the divider.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_RUN;
      image_size  <= DIM_W'(SIZE_RESET);
      filter_mode <= MODE_BOX;
      cnt         <= '0;
      row         <= '0;
      col         <= '0;
      front.valid <= 1'b0;
    end else begin
      state       <= state_next;
      front.valid <= accept;
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_SIZE:  image_size  <= cfg_data;
          REG_FILTER_MODE: filter_mode <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (last_item) begin
          cnt <= '0;
          row <= '0;
          col <= '0;
        end else if (col_end) begin
          cnt <= cnt + CNT_W'(1);
          row <= row + ROW_W'(1);
          col <= '0;
        end else begin
          cnt <= cnt + CNT_W'(1);
          col <= col + COL_W'(1);
        end
      end
      if (state == ST_DIV && !div_start && div_last) begin
        if (div_over) begin
          cnt <= '0;
          row <= '0;
          col <= '0;
        end else begin
          row <= dvd_next[ROW_W-1:0];
          col <= rem_next[COL_W-1:0];
        end
      end
    end
  end

  // Divider working registers and the accepted item.
  always_ff @(posedge clk) begin
    if (div_start) begin
      dvd  <= cnt;
      rem  <= '0;
      step <= '0;
    end else if (state == ST_DIV) begin
      dvd  <= dvd_next;
      rem  <= rem_next;
      step <= step + STEP_W'(1);
    end
    front.col <= col;
    front.px  <= px;
    front.tag <= tag;
  end

endmodule

>>> rtl/rgb3_window.sv
// Line stores and 3x3 window of the RGB filter: reads both stores at the
// accepting edge, shifts the window and writes back in the cycle after it.
// Depends on rgb3_pkg and rgb3_ram.
module rgb3_window import rgb3_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  rd_req_t      rd_req,
  input  front_t       front,
  output pixel_t [8:0] win,
  output tag_t         w_tag
);

  pixel_t up_rdata, lw_rdata, up, lw;
  pixel_t fwd_up, fwd_lw;
  logic   fwd_q;

  // Upper store takes what leaves the lower one; lower takes the new pixel.
  rgb3_ram #(.WIDTH(24), .DEPTH(MAX_DIM)) u_upper (
    .clk   (clk),
    .we    (front.valid),
    .waddr (front.col),
    .wdata (lw),
    .raddr (rd_req.col),
    .rdata (up_rdata)
  );

  rgb3_ram #(.WIDTH(24), .DEPTH(MAX_DIM)) u_lower (
    .clk   (clk),
    .we    (front.valid),
    .waddr (front.col),
    .wdata (front.px),
    .raddr (rd_req.col),
    .rdata (lw_rdata)
  );

  // A read that met a write to the same column takes the written words.
  assign up = fwd_q ? fwd_up : up_rdata;
  assign lw = fwd_q ? fwd_lw : lw_rdata;

  always_ff @(posedge clk) begin
    fwd_up <= lw;
    fwd_lw <= front.px;
  end

  // Window shift, forwarding flag and result tag.
  always_ff @(posedge clk) begin
    if (rst) begin
      win   <= '0;
      fwd_q <= 1'b0;
      w_tag <= '0;
    end else begin
      fwd_q <= front.valid && rd_req.accept && (rd_req.col == front.col);
      w_tag.produce <= front.valid && front.tag.produce;
      if (front.valid) begin
        win[0] <= win[1];
        win[1] <= win[2];
        win[2] <= up;
        win[3] <= win[4];
        win[4] <= win[5];
        win[5] <= lw;
        win[6] <= win[7];
        win[7] <= win[8];
        win[8] <= front.px;
        w_tag.border    <= front.tag.border;
        w_tag.frame_end <= front.tag.frame_end;
      end
    end
  end

endmodule

>>> rtl/rgb3_kernel.sv
// Four-stage filter datapath of the RGB 3x3 window filter: sums and
// intensities, min/max search, per-mode value, reciprocal division.
// Depends on rgb3_pkg.
module rgb3_kernel import rgb3_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic [1:0]   filter_mode,
  input  pixel_t [8:0] win,
  input  tag_t         w_tag,
  output logic         res_valid,
  output result_t      res
);

  // Stage 1 registers.
  tag_t               s1_tag;
  pixel_t [8:0]       s1_px;
  logic [2:0][11:0]   s1_sum;
  logic [8:0][9:0]    s1_int;
  // Stage 2 registers.
  tag_t               s2_tag;
  pixel_t [8:0]       s2_px;
  logic [2:0][11:0]   s2_sum;
  logic [3:0]         s2_lo, s2_hi;
  // Stage 3 registers.
  tag_t               s3_tag;
  logic [2:0][11:0]   s3_val;
  logic               s3_div;
  logic [12:0]        s3_recip;

  logic [2:0][11:0]   sum_c;
  logic [8:0][9:0]    int_c;
  logic [3:0]         lo_c, hi_c;
  logic [2:0][11:0]   val_c;
  logic [2:0][7:0]    out_c;

  // Channel sums and intensities of the window.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_c[k] = '0;
      for (int i = 0; i < 9; i++) begin
        sum_c[k] = sum_c[k] + 12'(chan(win[i], k));
      end
    end
    for (int i = 0; i < 9; i++) begin
      int_c[i] = 10'(win[i].r) + 10'(win[i].g) + 10'(win[i].b);
    end
  end

  // Lowest intensity (last on ties) and highest (first on ties).
  always_comb begin
    logic [9:0] lo_v;
    logic [9:0] hi_v;
    logic       hi_set;
    lo_v   = INT_SEED;
    hi_v   = '0;
    hi_set = 1'b0;
    lo_c   = '0;
    hi_c   = '0;
    for (int i = 0; i < 9; i++) begin
      if (s1_int[i] <= lo_v) begin
        lo_v = s1_int[i];
        lo_c = 4'(i);
      end
      if (!hi_set || s1_int[i] > hi_v) begin
        hi_v   = s1_int[i];
        hi_c   = 4'(i);
        hi_set = 1'b1;
      end
    end
  end

  // Value per channel before any division.
  always_comb begin
    logic [11:0] ctr;
    logic [11:0] pos;
    logic [11:0] diff;
    for (int k = 0; k < 3; k++) begin
      ctr  = 12'(chan(s2_px[4], k));
      pos  = 12'(ctr * 12'd10);
      diff = pos - s2_sum[k];
      if (s2_tag.border) begin
        val_c[k] = ctr;
      end else begin
        case (filter_mode)
          MODE_BOX:     val_c[k] = s2_sum[k];
          MODE_SHARPEN: begin
            if (pos <= s2_sum[k]) val_c[k] = '0;
            else if (diff > 12'd255) val_c[k] = 12'd255;
            else val_c[k] = diff;
          end
          MODE_TRIM:    val_c[k] = s2_sum[k] - 12'(chan(s2_px[s2_lo], k))
                                   - 12'(chan(s2_px[s2_hi], k));
          default:      val_c[k] = ctr;
        endcase
      end
    end
  end

  // Division by nine or seven through the reciprocal.
  always_comb begin
    logic [24:0] prod;
    for (int k = 0; k < 3; k++) begin
      prod = 25'(s3_val[k]) * 25'(s3_recip);
      if (s3_div) out_c[k] = prod[RECIP_SH+7:RECIP_SH];
      else out_c[k] = s3_val[k][7:0];
    end
  end

  // Pipeline valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag.produce <= 1'b0;
      s2_tag.produce <= 1'b0;
      s3_tag.produce <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      s1_tag.produce <= w_tag.produce;
      s2_tag.produce <= s1_tag.produce;
      s3_tag.produce <= s2_tag.produce;
      res_valid      <= s3_tag.produce;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    s1_tag.border    <= w_tag.border;
    s1_tag.frame_end <= w_tag.frame_end;
    s1_px            <= win;
    s1_sum           <= sum_c;
    s1_int           <= int_c;

    s2_tag.border    <= s1_tag.border;
    s2_tag.frame_end <= s1_tag.frame_end;
    s2_px            <= s1_px;
    s2_sum           <= s1_sum;
    s2_lo            <= lo_c;
    s2_hi            <= hi_c;

    s3_tag.border    <= s2_tag.border;
    s3_tag.frame_end <= s2_tag.frame_end;
    s3_val           <= val_c;
    s3_div           <= !s2_tag.border &&
                        (filter_mode == MODE_BOX || filter_mode == MODE_TRIM);
    s3_recip         <= (filter_mode == MODE_BOX) ? RECIP_9 : RECIP_7;

    res.frame_end    <= s3_tag.frame_end;
    res.px.r         <= out_c[0];
    res.px.g         <= out_c[1];
    res.px.b         <= out_c[2];
  end

endmodule

>>> rtl/rgb_3x3_window_filter.sv
// Top level of the RGB 3x3 window filter: control, line stores and window,
// filter datapath, and the output queue with its credit count.
// Depends on rgb3_pkg, rgb3_ctrl, rgb3_window, rgb3_kernel and the macros.
//
//  channel  | direction | handshake                     | payload
//  s_axis   | in        | s_axis_tvalid / s_axis_tready | tdata red,green,blue; tuser kind
//  m_axis   | out       | m_axis_tvalid / m_axis_tready | tdata red,green,blue; tlast
//  cfg      | in        | cfg_we                        | cfg_index, cfg_data
//
// One word is taken per clock while input is not stalled; each result passes
// the line store read, the window register and the four filter stages to the output queue.
// Writing image_size stalls input while a serial divider re-derives the row and column.
// Reset is synchronous and needs no clearing pass.
// Input stalls when eight results are in flight or queued, and while the divider runs.
`include "rgb_3x3_window_filter_macros.svh"
module rgb_3x3_window_filter import rgb3_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,  // in_red, in_green, in_blue
  input  logic                 s_axis_tuser,  // operation
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [23:0]          m_axis_tdata,  // out_red, out_green, out_blue
  output logic                 m_axis_tlast
);

  rd_req_t              rd_req;
  front_t               front;
  logic                 claim, room, res_valid, pop;
  logic [1:0]           filter_mode;
  pixel_t [8:0]         win;
  tag_t                 w_tag;
  result_t              res;
  result_t              oq [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [OQ_CNT_W-1:0]  count, used;

  rgb3_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .room          (room),
    .s_axis_tready (s_axis_tready),
    .rd_req        (rd_req),
    .front         (front),
    .claim         (claim),
    .filter_mode   (filter_mode)
  );

  rgb3_window u_window (
    .clk    (clk),
    .rst    (rst),
    .rd_req (rd_req),
    .front  (front),
    .win    (win),
    .w_tag  (w_tag)
  );

  rgb3_kernel u_kernel (
    .clk         (clk),
    .rst         (rst),
    .filter_mode (filter_mode),
    .win         (win),
    .w_tag       (w_tag),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Output queue; a word is claimed at input so the queue never overflows.
  assign room          = (used < OQ_CNT_W'(OQ_DEPTH));
  assign m_axis_tvalid = (count != '0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = {oq[rd_ptr].px.b, oq[rd_ptr].px.g, oq[rd_ptr].px.r};
  assign m_axis_tlast  = oq[rd_ptr].frame_end;

  always_ff @(posedge clk) begin
    if (res_valid) begin
      oq[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      used   <= '0;
    end else begin
      if (res_valid) wr_ptr <= wr_ptr + OQ_PTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + OQ_PTR_W'(1);
      case ({res_valid, pop})
        2'b10:   count <= count + OQ_CNT_W'(1);
        2'b01:   count <= count - OQ_CNT_W'(1);
        default: count <= count;
      endcase
      case ({claim, pop})
        2'b10:   used <= used + OQ_CNT_W'(1);
        2'b01:   used <= used - OQ_CNT_W'(1);
        default: used <= used;
      endcase
    end
  end

  // Credit and queue consistency.
  `RGB3_ASSERT_SAME(a_used_bound, 1'b1, used <= OQ_CNT_W'(OQ_DEPTH), "credit count overflow")
  `RGB3_ASSERT_SAME(a_used_covers, 1'b1, used >= count, "queue holds unclaimed words")
  `RGB3_ASSERT_SAME(a_no_overflow, res_valid, (count < OQ_CNT_W'(OQ_DEPTH)) || pop, "queue overflow")
  `RGB3_ASSERT_NEXT(a_claim_room, claim && !pop, used != '0, "claim not counted")

endmodule

>>> bench/rgb_3x3_window_filter_checker.sv
`timescale 1ns / 1ps
// Checker for the RGB 3x3 window filter: watches the register port and both
// streams, predicts each output word and compares it. Depends on rgb3_pkg.
module rgb_3x3_window_filter_checker import rgb3_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,
  input  logic                 s_axis_tuser,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [23:0]          m_axis_tdata,
  input  logic                 m_axis_tlast,
  output int                   pending,
  output int                   failures
);

  // Predictor state: configuration, line stores, window and frame position.
  logic [DIM_W-1:0] side_reg;
  logic [1:0]       mode_reg;
  pixel_t           upper_line [MAX_DIM];
  pixel_t           lower_line [MAX_DIM];
  pixel_t           win [9];
  int unsigned      pos;
  result_t          filtered_q [$];

  function automatic int unsigned chan_of(pixel_t p, int k);
    return (k == 0) ? p.r : (k == 1) ? p.g : p.b;
  endfunction

  // Filter of an inner pixel from the current window.
  function automatic pixel_t inner_pixel();
    int unsigned lo, hi, v, lo_v, sum, ctr, c;
    int hi_v;
    pixel_t res;
    lo = 0; hi = 0; lo_v = 766; hi_v = -1;
    res = '0;
    for (int i = 0; i < 9; i++) begin
      v = win[i].r + win[i].g + win[i].b;
      if (v <= lo_v) begin
        lo_v = v; lo = i;
      end
      if (int'(v) > hi_v) begin
        hi_v = v; hi = i;
      end
    end
    for (int k = 0; k < 3; k++) begin
      sum = 0;
      for (int i = 0; i < 9; i++) sum += chan_of(win[i], k);
      ctr = chan_of(win[4], k);
      case (mode_reg)
        MODE_BOX:     c = sum / 9;
        MODE_SHARPEN: begin
          if (10 * ctr <= sum) c = 0;
          else c = (10 * ctr - sum > 255) ? 255 : 10 * ctr - sum;
        end
        MODE_TRIM:    c = (sum - chan_of(win[lo], k) - chan_of(win[hi], k)) / 7;
        default:      c = ctr;
      endcase
      if (k == 0) res.r = c[7:0];
      else if (k == 1) res.g = c[7:0];
      else res.b = c[7:0];
    end
    return res;
  endfunction

  // Advance the window by one word and queue the pixel it releases, if any.
  task automatic shift_word(logic op, logic [23:0] data);
    int unsigned n, total, col, p, r, c;
    pixel_t px, up, lw;
    result_t res;
    n = (side_reg == 0) ? 1 : (side_reg > MAX_DIM) ? MAX_DIM : side_reg;
    total = n * n + n + 1;
    if (pos >= total) pos = 0;
    col = pos % n;
    px = (op == OP_PIXEL) ? pixel_t'{data[7:0], data[15:8], data[23:16]} : '0;
    up = upper_line[col];
    lw = lower_line[col];
    win[0] = win[1]; win[1] = win[2]; win[2] = up;
    win[3] = win[4]; win[4] = win[5]; win[5] = lw;
    win[6] = win[7]; win[7] = win[8]; win[8] = px;
    upper_line[col] = lw;
    lower_line[col] = px;
    if (pos >= n + 1) begin
      p = pos - (n + 1);
      r = p / n;
      c = p % n;
      if (r == 0 || c == 0 || r == n - 1 || c == n - 1) res.px = win[4];
      else res.px = inner_pixel();
      res.frame_end = (p == n * n - 1);
      filtered_q.push_back(res);
    end
    pos++;
    if (pos >= total) pos = 0;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      side_reg <= DIM_W'(SIZE_RESET);
      mode_reg <= MODE_BOX;
      foreach (win[i]) win[i] = '0;
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        lower_line[i] = '0;
      end
      pos = 0;
      filtered_q.delete();
      failures = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_IMAGE_SIZE) side_reg <= cfg_data;
        else mode_reg <= cfg_data[1:0];
      end
      if (s_axis_tvalid && s_axis_tready) shift_word(s_axis_tuser, s_axis_tdata);
      // Compare each output word against the oldest prediction.
      if (m_axis_tvalid && m_axis_tready) begin
        if (filtered_q.size() == 0) begin
          $error("output word with no prediction waiting: tdata %h", m_axis_tdata);
          failures++;
        end else begin
          want = filtered_q.pop_front();
          if (m_axis_tdata[7:0] !== want.px.r) begin
            $error("out_red: expected %0d, got %0d", want.px.r, m_axis_tdata[7:0]);
            failures++;
          end
          if (m_axis_tdata[15:8] !== want.px.g) begin
            $error("out_green: expected %0d, got %0d", want.px.g, m_axis_tdata[15:8]);
            failures++;
          end
          if (m_axis_tdata[23:16] !== want.px.b) begin
            $error("out_blue: expected %0d, got %0d", want.px.b, m_axis_tdata[23:16]);
            failures++;
          end
          if (m_axis_tlast !== want.frame_end) begin
            $error("frame_end: expected %0d, got %0d", want.frame_end, m_axis_tlast);
            failures++;
          end
        end
      end
    end
    pending = filtered_q.size();
  end

endmodule

>>> bench/rgb_3x3_window_filter_tb.sv
`timescale 1ns / 1ps
// Testbench top of the RGB 3x3 window filter: clock, reset, stimulus and the
// verdict. Depends on rgb3_pkg, rgb_3x3_window_filter and its checker.
module rgb_3x3_window_filter_tb import rgb3_pkg::*;;

  localparam longint CYCLE_LIMIT = 8_000_000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_IMAGE_SIZE;
  logic [DIM_W-1:0]     cfg_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata = '0;
  logic                 s_axis_tuser = OP_PIXEL;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [23:0]          m_axis_tdata;
  logic                 m_axis_tlast;
  int                   pending;
  int                   failures;
  longint               cycles = 0;
  int                   words_sent = 0;
  bit                   calm = 1'b0;
  int                   stall_left = 0;

  always #5 clk = ~clk;

  rgb_3x3_window_filter dut (.*);

  rgb_3x3_window_filter_checker checker_i (.*);

  // Give up on a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("rgb_3x3_window_filter regression: fail");
      $finish;
    end
  end

  // Receiver: mostly ready, short stalls and now and then a long one.
  always @(posedge clk) begin
    if (calm) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(99) < 3) begin
      stall_left <= $urandom_range(40, 10);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) < 75);
    end
  end

  function automatic int gap_len();
    int roll;
    roll = $urandom_range(99);
    if (calm || roll < 65) return 0;
    if (roll < 96) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // One channel value, often from the extremes so that intensities tie.
  function automatic logic [7:0] channel_value(bit plain);
    logic [7:0] pick [4] = '{8'd0, 8'd255, 8'd128, 8'd1};
    if (plain) return 8'($urandom_range(255));
    return pick[$urandom_range(3)];
  endfunction

  task automatic send_word(logic op, logic [23:0] data);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= data;
    do @(posedge clk); while (!s_axis_tready);
    words_sent++;
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Register writes only once the block has drained.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One whole frame plus its flush words; misplace_pct percent of the words carry the wrong kind.
  task automatic send_frame(logic [DIM_W-1:0] side, bit plain, int misplace_pct);
    int unsigned n, pixels;
    logic op;
    logic [23:0] data;
    n = (side == 0) ? 1 : (side > MAX_DIM) ? MAX_DIM : side;
    pixels = n * n;
    for (int unsigned i = 0; i < pixels + n + 1; i++) begin
      op = (i < pixels) ? OP_PIXEL : OP_FLUSH;
      if ($urandom_range(99) < misplace_pct) op = ~op;
      data = {channel_value(plain), channel_value(plain), channel_value(plain)};
      send_word(op, data);
    end
  endtask

  initial begin
    int unsigned side;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero size acting as one, then a small sharpened frame of extremes.
    write_reg(REG_IMAGE_SIZE, 11'd0);
    write_reg(REG_FILTER_MODE, {9'd0, MODE_TRIM});
    send_frame(11'd0, 1'b0, 0);
    write_reg(REG_IMAGE_SIZE, 11'd3);
    write_reg(REG_FILTER_MODE, {9'h1FF, MODE_SHARPEN});
    send_frame(11'd3, 1'b0, 0);

    // Random frames of small sizes in every mode.
    while (words_sent < 1250) begin
      calm = ($urandom_range(9) == 0);
      side = ($urandom_range(9) == 0) ? $urandom_range(24, 13) : $urandom_range(12, 1);
      write_reg(REG_IMAGE_SIZE, DIM_W'(side));
      write_reg(REG_FILTER_MODE, {9'($urandom_range(511)), 2'($urandom_range(3))});
      send_frame(DIM_W'(side), 1'($urandom_range(1)), ($urandom_range(3) == 0) ? 6 : 0);
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (failures == 0) begin
      $display("rgb_3x3_window_filter regression: pass");
    end else begin
      $display("rgb_3x3_window_filter regression: fail");
    end
    $finish;
  end

endmodule
